// ===== rtl/core/pgalloc_pkg.sv =====
// pgalloc_pkg: request, status, register and state codes for the page allocator
// standalone package, used by page_allocator_with_refcount
package pgalloc_pkg;

  localparam int ADDR_W    = 64;
  localparam int CNT_OUT_W = 16;
  localparam int PCNT_W    = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 2'd1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INC   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_BAD_ADDR = 2'd2,
    STAT_UNREF    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

endpackage

// ===== rtl/core/page_allocator_with_refcount.sv =====
// page_allocator_with_refcount: free-page stack and per-page reference counts
// held in two synchronous memories; depends on pgalloc_pkg
//
// Each request is handled as follows: the cycle in which start is taken reads the
// count memory (and the top of the free stack), the next cycle writes back the
// modified count and any push, and the result appears on done for exactly one
// cycle right after; busy is high in between, so a new request can be taken in
// that same result cycle. The receiver cannot stall results. Writing
// page_count starts an initialization pass over min(page_count, NUM_PAGES)
// pages, one page per cycle, during which busy stays high; configuration
// writes are always taken (cfg_ready is tied high).
module page_allocator_with_refcount #(
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12,
  parameter int REF_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            mode,
  input  logic [pgalloc_pkg::ADDR_W-1:0]        page_address,
  output logic                                  done,
  output logic [pgalloc_pkg::ADDR_W-1:0]        alloc_address,
  output logic [pgalloc_pkg::CNT_OUT_W-1:0]     ref_count,
  output logic [1:0]                            status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pgalloc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgalloc_pkg::ADDR_W-1:0]        cfg_data
);

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int DEP_W = $clog2(NUM_PAGES + 1);
  localparam int HI_W  = pgalloc_pkg::ADDR_W - PAGE_SHIFT;

  // configuration and control
  pgalloc_pkg::state_t state, state_next;
  logic [pgalloc_pkg::ADDR_W-1:0] base_address;
  logic [DEP_W-1:0]               page_count;
  logic [DEP_W-1:0]               depth, depth_next;
  logic [DEP_W-1:0]               sweep_idx;

  // request latched at accept
  pgalloc_pkg::mode_t op_mode;
  logic               op_bad;
  logic [IDX_W-1:0]   op_idx;

  // memories
  logic [IDX_W-1:0]    stack_mem [NUM_PAGES];
  logic [REF_BITS-1:0] ref_mem   [NUM_PAGES];
  logic [IDX_W-1:0]    stk_rdata;
  logic [REF_BITS-1:0] ref_rdata;
  logic                stk_we, ref_we;
  logic [IDX_W-1:0]    stk_waddr, stk_wdata, ref_waddr;
  logic [REF_BITS-1:0] ref_wdata;

  // address check
  logic [pgalloc_pkg::ADDR_W-1:0] offset;
  logic                           addr_bad;
  logic [IDX_W-1:0]               addr_idx;
  logic [IDX_W-1:0]               stk_raddr;

  // config decode
  logic                  cfg_fire, pc_write;
  logic [31:0]           pc_wide;
  logic [DEP_W-1:0]      pc_clamped;

  // result
  logic [pgalloc_pkg::ADDR_W-1:0] res_addr;
  logic [REF_BITS-1:0]            res_cnt;
  pgalloc_pkg::status_t           res_status;
  logic [REF_BITS-1:0]            cnt_mod;
  logic                           accept;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign pc_write  = cfg_fire && (cfg_index == pgalloc_pkg::CFG_PAGE_COUNT);
  assign pc_wide   = 32'(cfg_data[pgalloc_pkg::PCNT_W-1:0]);
  assign pc_clamped = (pc_wide > 32'(NUM_PAGES)) ? DEP_W'(NUM_PAGES) : DEP_W'(pc_wide);

  assign busy   = (state != pgalloc_pkg::ST_IDLE);
  assign accept = start && !busy;

  // range check: below base, misaligned (free only), page index past the pool
  assign offset   = page_address - base_address;
  assign addr_idx = offset[PAGE_SHIFT +: IDX_W];
  assign addr_bad = (page_address < base_address)
                 || (offset[pgalloc_pkg::ADDR_W-1:PAGE_SHIFT] >= HI_W'(page_count))
                 || ((pgalloc_pkg::mode_t'(mode) == pgalloc_pkg::MODE_FREE)
                     && (|offset[PAGE_SHIFT-1:0]));
  assign stk_raddr = IDX_W'(depth - DEP_W'(1));

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (accept) stk_rdata <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (accept) ref_rdata <= ref_mem[addr_idx];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= pgalloc_pkg::mode_t'(mode);
      op_bad  <= addr_bad;
      op_idx  <= addr_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pgalloc_pkg::ST_IDLE;
      base_address <= '0;
      page_count   <= '0;
      depth        <= '0;
      sweep_idx    <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      done  <= (state == pgalloc_pkg::ST_EXEC);
      if (cfg_fire && (cfg_index == pgalloc_pkg::CFG_BASE_ADDRESS)) begin
        base_address <= cfg_data;
      end
      if (pc_write) begin
        page_count <= pc_clamped;
        sweep_idx  <= '0;
      end else if (state == pgalloc_pkg::ST_SWEEP) begin
        sweep_idx <= sweep_idx + DEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pgalloc_pkg::ST_EXEC) begin
      alloc_address <= res_addr;
      ref_count     <= pgalloc_pkg::CNT_OUT_W'(res_cnt);
      status        <= res_status;
    end
  end

  always_comb begin
    state_next = state;
    depth_next = depth;
    stk_we     = 1'b0;
    stk_waddr  = depth[IDX_W-1:0];
    stk_wdata  = op_idx;
    ref_we     = 1'b0;
    ref_waddr  = op_idx;
    ref_wdata  = '0;
    res_addr   = '0;
    res_cnt    = '0;
    res_status = pgalloc_pkg::STAT_OK;
    cnt_mod    = '0;

    unique case (state)
      pgalloc_pkg::ST_IDLE: begin
        if (accept) state_next = pgalloc_pkg::ST_EXEC;
      end
      pgalloc_pkg::ST_EXEC: begin
        state_next = pgalloc_pkg::ST_IDLE;
        unique case (op_mode)
          pgalloc_pkg::MODE_ALLOC: begin
            if (depth == '0) begin
              res_status = pgalloc_pkg::STAT_EMPTY;
            end else begin
              depth_next = depth - DEP_W'(1);
              ref_we     = 1'b1;
              ref_waddr  = stk_rdata;
              ref_wdata  = REF_BITS'(1);
              res_cnt    = REF_BITS'(1);
              res_addr   = base_address + (pgalloc_pkg::ADDR_W'(stk_rdata) << PAGE_SHIFT);
            end
          end
          pgalloc_pkg::MODE_FREE: begin
            cnt_mod = ref_rdata - REF_BITS'(1);
            if (op_bad) begin
              res_status = pgalloc_pkg::STAT_BAD_ADDR;
            end else if (ref_rdata == '0) begin
              res_status = pgalloc_pkg::STAT_UNREF;
            end else begin
              ref_we    = 1'b1;
              ref_wdata = cnt_mod;
              res_cnt   = cnt_mod;
              // last reference gone: page goes back on the stack unless full
              if ((cnt_mod == '0) && (depth < DEP_W'(NUM_PAGES))) begin
                stk_we     = 1'b1;
                depth_next = depth + DEP_W'(1);
              end
            end
          end
          pgalloc_pkg::MODE_INC: begin
            cnt_mod = (ref_rdata == '1) ? ref_rdata : ref_rdata + REF_BITS'(1);
            if (op_bad) begin
              res_status = pgalloc_pkg::STAT_BAD_ADDR;
            end else begin
              ref_we    = 1'b1;
              ref_wdata = cnt_mod;
              res_cnt   = cnt_mod;
            end
          end
          pgalloc_pkg::MODE_QUERY: begin
            if (op_bad) res_status = pgalloc_pkg::STAT_BAD_ADDR;
            else res_cnt = ref_rdata;
          end
        endcase
      end
      pgalloc_pkg::ST_SWEEP: begin
        // one page per cycle: clear its count, place its index on the stack
        stk_we    = 1'b1;
        stk_waddr = sweep_idx[IDX_W-1:0];
        stk_wdata = sweep_idx[IDX_W-1:0];
        ref_we    = 1'b1;
        ref_waddr = sweep_idx[IDX_W-1:0];
        ref_wdata = '0;
        if (sweep_idx + DEP_W'(1) == page_count) state_next = pgalloc_pkg::ST_IDLE;
      end
      default: state_next = pgalloc_pkg::ST_IDLE;
    endcase

    if (pc_write) begin
      depth_next = pc_clamped;
      state_next = (pc_clamped == '0) ? pgalloc_pkg::ST_IDLE : pgalloc_pkg::ST_SWEEP;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == pgalloc_pkg::ST_EXEC))
    else $error("result strobe without an executing request");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEP_W'(NUM_PAGES))
    else $error("free stack depth beyond capacity");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != pgalloc_pkg::STAT_OK)) |-> (ref_count == '0 && alloc_address == '0))
    else $error("failed request reports a count or an address");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == pgalloc_pkg::ST_SWEEP) |-> (sweep_idx < page_count))
    else $error("initialization pass past the pool");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == pgalloc_pkg::ST_EXEC) |=> !(state == pgalloc_pkg::ST_EXEC) || $past(pc_write))
    else $error("request overlapped a running one");

endmodule

// ===== bench/page_alloc_check.sv =====
`timescale 1ns / 100ps
// page_alloc_check: watches the request, result and register channels of the page allocator,
// keeps its own model of the free stack and the counts, and compares every result
// depends on pgalloc_pkg
module page_alloc_check #(
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12,
  parameter int REF_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        mode,
  input  logic [pgalloc_pkg::ADDR_W-1:0]    page_address,
  input  logic                              done,
  input  logic [pgalloc_pkg::ADDR_W-1:0]    alloc_address,
  input  logic [pgalloc_pkg::CNT_OUT_W-1:0] ref_count,
  input  logic [1:0]                        status,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pgalloc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgalloc_pkg::ADDR_W-1:0]    cfg_data,
  output int                                pending,
  output int                                fail_count
);

  typedef struct packed {
    logic [pgalloc_pkg::ADDR_W-1:0]    addr;
    logic [pgalloc_pkg::CNT_OUT_W-1:0] cnt;
    pgalloc_pkg::status_t              st;
  } alloc_result_t;

  localparam longint unsigned CNT_LIMIT = (64'd1 << REF_BITS) - 64'd1;
  localparam logic [pgalloc_pkg::ADDR_W-1:0] OFS_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

  logic [pgalloc_pkg::ADDR_W-1:0] base_q;
  int unsigned       npages;
  int unsigned       top;
  int unsigned       free_pages [NUM_PAGES];
  longint unsigned   refs [NUM_PAGES];
  alloc_result_t     result_q [$];
  alloc_result_t     want;

  // all counts cleared, every page of the pool pushed in ascending order
  function automatic void clear_pool();
    for (int i = 0; i < NUM_PAGES; i++) begin
      refs[i] = 0;
      free_pages[i] = (i < npages) ? i : 0;
    end
    top = npages;
  endfunction

  function automatic void apply_write(input logic [pgalloc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [pgalloc_pkg::ADDR_W-1:0] d);
    if (idx == pgalloc_pkg::CFG_BASE_ADDRESS) begin
      base_q = d;
    end else if (idx == pgalloc_pkg::CFG_PAGE_COUNT) begin
      npages = (d[pgalloc_pkg::PCNT_W-1:0] > NUM_PAGES) ? NUM_PAGES
                                                        : d[pgalloc_pkg::PCNT_W-1:0];
      clear_pool();
    end
  endfunction

  function automatic bit locate_page(input logic [pgalloc_pkg::ADDR_W-1:0] a,
                                     input bit aligned, output int unsigned pg);
    logic [pgalloc_pkg::ADDR_W-1:0] off;
    pg = 0;
    if (a < base_q) return 1'b0;
    off = a - base_q;
    if (aligned && ((off & OFS_MASK) != '0)) return 1'b0;
    off = off >> PAGE_SHIFT;
    if (off >= 64'(npages)) return 1'b0;
    pg = off[31:0];
    return 1'b1;
  endfunction

  function automatic alloc_result_t serve(input logic [1:0] m,
                                          input logic [pgalloc_pkg::ADDR_W-1:0] a);
    alloc_result_t r;
    int unsigned   pg;
    r.addr = '0;
    r.cnt  = '0;
    r.st   = pgalloc_pkg::STAT_OK;
    case (m)
      pgalloc_pkg::MODE_ALLOC: begin
        if (top == 0 || top > NUM_PAGES) begin
          r.st = pgalloc_pkg::STAT_EMPTY;
        end else begin
          top--;
          pg = free_pages[top] % NUM_PAGES;
          refs[pg] = 1;
          r.cnt = 1;
          r.addr = base_q + (64'(pg) << PAGE_SHIFT);
        end
      end
      pgalloc_pkg::MODE_FREE: begin
        if (!locate_page(a, 1'b1, pg)) begin
          r.st = pgalloc_pkg::STAT_BAD_ADDR;
        end else if (refs[pg] == 0) begin
          r.st = pgalloc_pkg::STAT_UNREF;
        end else begin
          refs[pg]--;
          // a push onto a full stack is dropped
          if (refs[pg] == 0 && top < NUM_PAGES) begin
            free_pages[top] = pg;
            top++;
          end
          r.cnt = pgalloc_pkg::CNT_OUT_W'(refs[pg]);
        end
      end
      pgalloc_pkg::MODE_INC: begin
        if (!locate_page(a, 1'b0, pg)) begin
          r.st = pgalloc_pkg::STAT_BAD_ADDR;
        end else begin
          if (refs[pg] < CNT_LIMIT) refs[pg]++;
          r.cnt = pgalloc_pkg::CNT_OUT_W'(refs[pg]);
        end
      end
      pgalloc_pkg::MODE_QUERY: begin
        if (!locate_page(a, 1'b0, pg)) r.st = pgalloc_pkg::STAT_BAD_ADDR;
        else r.cnt = pgalloc_pkg::CNT_OUT_W'(refs[pg]);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      base_q = '0;
      npages = 0;
      clear_pool();
      result_q.delete();
    end else begin
      // the result of an older item is retired before a new item is taken
      if (done) begin
        if (result_q.size() == 0) begin
          $error("result strobe with no item outstanding");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (alloc_address !== want.addr) begin
            $error("alloc_address: expected %h, got %h", want.addr, alloc_address);
            fail_count++;
          end
          if (ref_count !== want.cnt) begin
            $error("ref_count: expected %0d, got %0d", want.cnt, ref_count);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (start && !busy) result_q.push_back(serve(mode, page_address));
    end
    pending <= result_q.size();
  end

endmodule

// ===== bench/tb_page_allocator_with_refcount.sv =====
`timescale 1ns / 100ps
// tb_page_allocator_with_refcount: drives requests and register writes into the page
// allocator; depends on pgalloc_pkg, page_allocator_with_refcount and page_alloc_check
module tb_page_allocator_with_refcount;

  localparam int MAX_PG       = 4096;
  localparam int PG_SHIFT     = 12;
  localparam int CNT_BITS     = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;

  // indexes with no register behind them
  localparam logic [pgalloc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
  localparam logic [pgalloc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        mode = pgalloc_pkg::MODE_ALLOC;
  logic [pgalloc_pkg::ADDR_W-1:0]    page_address = '0;
  logic                              done;
  logic [pgalloc_pkg::ADDR_W-1:0]    alloc_address;
  logic [pgalloc_pkg::CNT_OUT_W-1:0] ref_count;
  logic [1:0]                        status;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [pgalloc_pkg::CFG_IDX_W-1:0] cfg_index = pgalloc_pkg::CFG_BASE_ADDRESS;
  logic [pgalloc_pkg::ADDR_W-1:0]    cfg_data = '0;

  int                                pending;
  int                                fail_count;
  int                                cycles = 0;
  int                                gap_max = 3;
  logic [pgalloc_pkg::ADDR_W-1:0]    cur_base = '0;
  int unsigned                       cur_pages = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  page_allocator_with_refcount #(
    .NUM_PAGES (MAX_PG),
    .PAGE_SHIFT(PG_SHIFT),
    .REF_BITS  (CNT_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .page_address (page_address),
    .done         (done),
    .alloc_address(alloc_address),
    .ref_count    (ref_count),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  page_alloc_check #(
    .NUM_PAGES (MAX_PG),
    .PAGE_SHIFT(PG_SHIFT),
    .REF_BITS  (CNT_BITS)
  ) i_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .page_address (page_address),
    .done         (done),
    .alloc_address(alloc_address),
    .ref_count    (ref_count),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [pgalloc_pkg::ADDR_W-1:0] page_addr(input int unsigned pg);
    return cur_base + (64'(pg) << PG_SHIFT);
  endfunction

  // start stays high across back-to-back items
  task automatic issue(input pgalloc_pkg::mode_t m,
                       input logic [pgalloc_pkg::ADDR_W-1:0] a);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    page_address <= a;
    do @(posedge clk); while (busy);
  endtask

  // register writes only once every result is in and the block is idle
  task automatic write_reg(input logic [pgalloc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pgalloc_pkg::ADDR_W-1:0] d);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pool(input logic [pgalloc_pkg::ADDR_W-1:0] b,
                          input logic [pgalloc_pkg::ADDR_W-1:0] pcd);
    write_reg(pgalloc_pkg::CFG_BASE_ADDRESS, b);
    cur_base = b;
    write_reg(pgalloc_pkg::CFG_PAGE_COUNT, pcd);
    cur_pages = (pcd[pgalloc_pkg::PCNT_W-1:0] > MAX_PG) ? MAX_PG
                                                         : pcd[pgalloc_pkg::PCNT_W-1:0];
  endtask

  task automatic random_item();
    pgalloc_pkg::mode_t             m;
    int unsigned                    pg;
    int unsigned                    span;
    int                             r;
    logic [pgalloc_pkg::ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 30) m = pgalloc_pkg::MODE_ALLOC;
    else if (r < 60) m = pgalloc_pkg::MODE_FREE;
    else if (r < 80) m = pgalloc_pkg::MODE_INC;
    else m = pgalloc_pkg::MODE_QUERY;
    // pages near the top of the stack are the ones that get allocated first
    if (cur_pages == 0) begin
      pg = $urandom_range(0, 3);
    end else if ($urandom_range(0, 2) != 0) begin
      span = (cur_pages > 16) ? 16 : cur_pages;
      pg = cur_pages - 1 - $urandom_range(0, span - 1);
    end else begin
      pg = $urandom_range(0, cur_pages - 1);
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      a = page_addr(pg);
      if (m == pgalloc_pkg::MODE_FREE) begin
        if ($urandom_range(0, 9) == 0) a = a + 64'($urandom_range(1, (1 << PG_SHIFT) - 1));
      end else if ($urandom_range(0, 1) == 0) begin
        a = a + 64'($urandom_range(1, (1 << PG_SHIFT) - 1));
      end
    end else if (r < 85) begin
      a = page_addr(cur_pages + $urandom_range(0, 3));
    end else if (r < 90) begin
      a = cur_base - 64'($urandom_range(1, 8192));
    end else begin
      a = {$urandom, $urandom};
    end
    issue(m, a);
  endtask

  initial begin
    logic [pgalloc_pkg::ADDR_W-1:0] b;
    logic [pgalloc_pkg::ADDR_W-1:0] pcd;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty pool straight out of reset
    issue(pgalloc_pkg::MODE_ALLOC, {$urandom, $urandom});
    issue(pgalloc_pkg::MODE_QUERY, '0);

    set_pool('0, 64'd0);
    set_pool(64'h0000_0000_8000_0000, 64'd4);
    repeat (5) issue(pgalloc_pkg::MODE_ALLOC, '0);
    issue(pgalloc_pkg::MODE_FREE, page_addr(3));
    issue(pgalloc_pkg::MODE_FREE, page_addr(3));
    issue(pgalloc_pkg::MODE_FREE, page_addr(1) + 64'd4);
    issue(pgalloc_pkg::MODE_FREE, cur_base - 64'd4096);
    issue(pgalloc_pkg::MODE_FREE, page_addr(4));
    issue(pgalloc_pkg::MODE_INC, page_addr(2) + 64'hFFF);
    issue(pgalloc_pkg::MODE_QUERY, page_addr(2) + 64'h800);
    issue(pgalloc_pkg::MODE_QUERY, page_addr(4));
    issue(pgalloc_pkg::MODE_INC, page_addr(3));
    issue(pgalloc_pkg::MODE_ALLOC, '0);
    issue(pgalloc_pkg::MODE_FREE, page_addr(2));
    issue(pgalloc_pkg::MODE_QUERY, page_addr(1));
    issue(pgalloc_pkg::MODE_FREE, page_addr(1));

    // pages past the top of the address space wrap around to zero
    set_pool(64'hFFFF_FFFF_FFFF_E000, 64'd4);
    repeat (4) issue(pgalloc_pkg::MODE_ALLOC, '0);
    issue(pgalloc_pkg::MODE_FREE, 64'h0000_0000_0000_1000);
    issue(pgalloc_pkg::MODE_QUERY, 64'hFFFF_FFFF_FFFF_F000);

    // oversized count clamps to a full pool; freeing a page that was never taken
    b = {$urandom, $urandom};
    b[PG_SHIFT-1:0] = '0;
    set_pool(b, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(pgalloc_pkg::MODE_INC, page_addr(0));
    issue(pgalloc_pkg::MODE_FREE, page_addr(0));
    issue(pgalloc_pkg::MODE_ALLOC, '0);
    issue(pgalloc_pkg::MODE_QUERY, page_addr(MAX_PG - 1) + 64'd1);
    write_reg(CFG_UNMAPPED_2, {$urandom, $urandom});
    write_reg(CFG_UNMAPPED_3, {$urandom, $urandom});
    issue(pgalloc_pkg::MODE_QUERY, page_addr(MAX_PG - 1));

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: b = '0;
        1: begin
          b = {$urandom, $urandom};
          b[PG_SHIFT-1:0] = '0;
        end
        2: b = 64'h0 - (64'($urandom_range(1, 8)) << PG_SHIFT);
        default: b = {$urandom, $urandom};
      endcase
      pcd = {$urandom, $urandom};
      case (ph)
        0: pcd[pgalloc_pkg::PCNT_W-1:0] = 13'h1FFF;
        1: pcd[pgalloc_pkg::PCNT_W-1:0] = 13'd0;
        2: pcd[pgalloc_pkg::PCNT_W-1:0] = 13'd1;
        3: pcd[pgalloc_pkg::PCNT_W-1:0] = 13'(MAX_PG);
        default: pcd[pgalloc_pkg::PCNT_W-1:0] = 13'($urandom_range(2, 24));
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED_2, {$urandom, $urandom});
      set_pool(b, pcd);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // moving the base keeps the counts and the stack
        if (k == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) begin
          b = {$urandom, $urandom};
          b[PG_SHIFT-1:0] = '0;
          write_reg(pgalloc_pkg::CFG_BASE_ADDRESS, b);
          cur_base = b;
        end
        random_item();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
